FILE: hw/rtl/sacl_pkg.sv
// Shared widths, command codes and register indexes for the cache model.
// No dependencies; the interfaces, the front and back parts and the top module import it.
package sacl_pkg;

   localparam int CMD_W        = 2;
   localparam int ADDR_IN_W    = 32;
   localparam int CNT_W        = 32;
   localparam int ADDED_W      = 2;
   localparam int SET_BITS_W   = 3;
   localparam int BLOCK_BITS_W = 5;
   localparam int WAYS_W       = 4;
   localparam int CSR_IDX_W    = 2;
   localparam int CSR_DATA_W   = 5;

   localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_STORE  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_MODIFY = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_SET_BITS   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK_BITS = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WAYS       = 2'd2;

   localparam logic [SET_BITS_W-1:0]   SET_BITS_RST   = 3'd4;
   localparam logic [BLOCK_BITS_W-1:0] BLOCK_BITS_RST = 5'd4;
   localparam logic [WAYS_W-1:0]       WAYS_RST       = 4'd1;

endpackage

FILE: hw/rtl/sacl_req_if.sv
// Access request channel: valid/ready handshake with command and address.
// Depends on sacl_pkg.
interface sacl_req_if import sacl_pkg::*;
();
   logic                 valid;
   logic                 ready;
   logic [CMD_W-1:0]     command;
   logic [ADDR_IN_W-1:0] address;

   modport source (output valid, command, address, input ready);
   modport sink (input valid, command, address, output ready);
endinterface

FILE: hw/rtl/sacl_rsp_if.sv
// Access result channel: valid/ready handshake with flags and running totals.
// Depends on sacl_pkg.
interface sacl_rsp_if import sacl_pkg::*;
();
   logic               valid;
   logic               ready;
   logic               hit;
   logic               miss;
   logic               evicted;
   logic [ADDED_W-1:0] hits_added;
   logic [CNT_W-1:0]   hit_total;
   logic [CNT_W-1:0]   miss_total;
   logic [CNT_W-1:0]   evict_total;

   modport source (output valid, hit, miss, evicted, hits_added, hit_total, miss_total,
                   evict_total, input ready);
   modport sink (input valid, hit, miss, evicted, hits_added, hit_total, miss_total,
                 evict_total, output ready);
endinterface

FILE: hw/rtl/sacl_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sacl_ram #(
   parameter int  WIDTH = 8,
   parameter int  DEPTH = 64,
   localparam int A_W   = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             we,
   input  logic [A_W-1:0]   waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic             re,
   input  logic [A_W-1:0]   raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

FILE: hw/rtl/sacl_fifo.sv
// Short item queue between the front and back parts.
// No dependencies.
module sacl_fifo #(
   parameter int  WIDTH = 8,
   parameter int  DEPTH = 2,
   localparam int PTR_W = $clog2(DEPTH),
   localparam int CT_W  = $clog2(DEPTH + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);

   logic [WIDTH-1:0] slots_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CT_W-1:0]  count_ff, count_in;
   logic             do_push, do_pop;

   assign push_ready = (count_ff != CT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = slots_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

FILE: hw/rtl/sacl_front.sv
// Front part: configuration registers, request intake and address split.
// Depends on sacl_pkg and sacl_req_if.
module sacl_front import sacl_pkg::*; #(
   parameter int  MAX_SET_BITS = 6,
   parameter int  MAX_WAYS     = 8,
   parameter int  ADDR_WIDTH   = 32,
   localparam int AW    = (ADDR_WIDTH < ADDR_IN_W) ? ADDR_WIDTH : ADDR_IN_W,
   localparam int SBW   = $clog2(MAX_SET_BITS + 1),
   localparam int WC_W  = $clog2(MAX_WAYS + 1),
   localparam int SH_W  = ((SBW > BLOCK_BITS_W) ? SBW : BLOCK_BITS_W) + 1
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_we,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_data,
   sacl_req_if.sink                req_ch,
   output logic                    q_valid,
   input  logic                    q_ready,
   output logic                    q_ignore,
   output logic                    q_modify,
   output logic [MAX_SET_BITS-1:0] q_row,
   output logic [AW-1:0]           q_tag,
   output logic [WC_W-1:0]         q_ways
);

   logic [SET_BITS_W-1:0]   set_bits_ff;
   logic [BLOCK_BITS_W-1:0] block_bits_ff;
   logic [WAYS_W-1:0]       ways_ff;
   logic [SBW-1:0]          s_sat;
   logic [SH_W-1:0]         shift;
   logic [AW-1:0]           addr;
   logic [AW-1:0]           addr_shifted;

   always_ff @(posedge clock) begin
      if (reset) begin
         set_bits_ff   <= SET_BITS_RST;
         block_bits_ff <= BLOCK_BITS_RST;
         ways_ff       <= WAYS_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_SET_BITS:   set_bits_ff   <= csr_data[SET_BITS_W-1:0];
            CSR_BLOCK_BITS: block_bits_ff <= csr_data[BLOCK_BITS_W-1:0];
            CSR_WAYS:       ways_ff       <= csr_data[WAYS_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      s_sat = (32'(set_bits_ff) > 32'(MAX_SET_BITS)) ? SBW'(MAX_SET_BITS)
                                                      : SBW'(set_bits_ff);
      addr         = req_ch.address[AW-1:0];
      addr_shifted = addr >> block_bits_ff;
      q_row        = addr_shifted[MAX_SET_BITS-1:0] & ~({MAX_SET_BITS{1'b1}} << s_sat);
      shift        = SH_W'(s_sat) + SH_W'(block_bits_ff);
      q_tag        = addr >> shift;
      if (ways_ff == '0) begin
         q_ways = WC_W'(1);
      end else if (32'(ways_ff) > 32'(MAX_WAYS)) begin
         q_ways = WC_W'(MAX_WAYS);
      end else begin
         q_ways = WC_W'(ways_ff);
      end
   end

   assign q_ignore = !((req_ch.command == CMD_LOAD) || (req_ch.command == CMD_STORE) ||
                       (req_ch.command == CMD_MODIFY));
   assign q_modify = (req_ch.command == CMD_MODIFY);
   assign q_valid  = req_ch.valid;
   assign req_ch.ready = q_ready;

endmodule

FILE: hw/rtl/sacl_back.sv
// Back part: set row read, tag compare, LRU update, row write and result register.
// Depends on sacl_pkg, sacl_rsp_if and sacl_ram.
module sacl_back import sacl_pkg::*; #(
   parameter int  MAX_SET_BITS = 6,
   parameter int  MAX_WAYS     = 8,
   parameter int  ADDR_WIDTH   = 32,
   localparam int AW       = (ADDR_WIDTH < ADDR_IN_W) ? ADDR_WIDTH : ADDR_IN_W,
   localparam int NUM_SETS = 1 << MAX_SET_BITS,
   localparam int WC_W     = $clog2(MAX_WAYS + 1),
   localparam int RK_W     = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1,
   localparam int VI_W     = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1,
   localparam int WAY_W    = 1 + RK_W + AW,
   localparam int ROW_DW   = MAX_WAYS * WAY_W
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    q_valid,
   output logic                    q_ready,
   input  logic                    q_ignore,
   input  logic                    q_modify,
   input  logic [MAX_SET_BITS-1:0] q_row,
   input  logic [AW-1:0]           q_tag,
   input  logic [WC_W-1:0]         q_ways,
   sacl_rsp_if.source              rsp_ch
);

   typedef enum logic {
      S_IDLE,
      S_UPDATE
   } state_type;

   state_type               state_ff, state_in;
   logic                    modify_ff, modify_in;
   logic [MAX_SET_BITS-1:0] row_ff, row_in;
   logic [AW-1:0]           tag_ff, tag_in;
   logic [WC_W-1:0]         ways_ff, ways_in;
   logic [NUM_SETS-1:0]     row_live_ff, row_live_in;
   logic [CNT_W-1:0]        hit_total_ff, hit_total_in;
   logic [CNT_W-1:0]        miss_total_ff, miss_total_in;
   logic [CNT_W-1:0]        evict_total_ff, evict_total_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    hit_ff, hit_in;
   logic                    miss_ff, miss_in;
   logic                    evicted_ff, evicted_in;
   logic [ADDED_W-1:0]      added_ff, added_in;

   logic                    out_free;
   logic                    load_ignore;
   logic                    load_update;
   logic                    ram_re;
   logic [ROW_DW-1:0]       rd_data;
   logic [ROW_DW-1:0]       wr_data;

   logic                    rd_valid [MAX_WAYS];
   logic [RK_W-1:0]         rd_rank  [MAX_WAYS];
   logic [AW-1:0]           rd_tag   [MAX_WAYS];
   logic                    in_use   [MAX_WAYS];
   logic                    vld      [MAX_WAYS];
   logic                    match    [MAX_WAYS];

   logic                    found, inv_found;
   logic [VI_W-1:0]         victim;
   logic [ADDED_W-1:0]      added_now;

   assign out_free    = !rsp_valid_ff || rsp_ch.ready;
   assign q_ready     = (state_ff == S_IDLE) && (!q_ignore || out_free);
   assign ram_re      = (state_ff == S_IDLE) && q_valid && !q_ignore;
   assign load_ignore = (state_ff == S_IDLE) && q_valid && q_ignore && out_free;
   assign load_update = (state_ff == S_UPDATE) && out_free;

   sacl_ram #(
      .WIDTH (ROW_DW),
      .DEPTH (NUM_SETS)
   ) u_row_ram (
      .clock (clock),
      .we    (load_update),
      .waddr (row_ff),
      .wdata (wr_data),
      .re    (ram_re),
      .raddr (q_row),
      .rdata (rd_data)
   );

   always_comb begin
      for (int k = 0; k < MAX_WAYS; k++) begin
         rd_tag[k]   = rd_data[k*WAY_W +: AW];
         rd_rank[k]  = rd_data[k*WAY_W + AW +: RK_W];
         rd_valid[k] = rd_data[k*WAY_W + AW + RK_W];
         in_use[k]   = (WC_W'(k) < ways_ff);
         vld[k]      = in_use[k] && row_live_ff[row_ff] && rd_valid[k];
         match[k]    = vld[k] && (rd_tag[k] == tag_ff);
      end
   end

   // Hit way, last invalid way and LRU way; then the rank update of the row.
   always_comb begin
      logic            lru_found;
      logic [VI_W-1:0] hw, inv, lru;
      logic [RK_W-1:0] lru_rank;
      logic [RK_W:0]   old_rank;
      logic            nv;
      logic [RK_W-1:0] nr;
      logic [AW-1:0]   nt;
      found     = 1'b0;
      inv_found = 1'b0;
      lru_found = 1'b0;
      hw        = '0;
      inv       = '0;
      lru       = '0;
      lru_rank  = '0;
      for (int i = 0; i < MAX_WAYS; i++) begin
         if (match[i] && !found) begin
            found = 1'b1;
            hw    = VI_W'(i);
         end
         if (in_use[i] && !vld[i]) begin
            inv_found = 1'b1;
            inv       = VI_W'(i);
         end
         if (vld[i] && !match[i] && (!lru_found || (rd_rank[i] > lru_rank))) begin
            lru_found = 1'b1;
            lru       = VI_W'(i);
            lru_rank  = rd_rank[i];
         end
      end
      if (found) begin
         victim   = hw;
         old_rank = {1'b0, rd_rank[hw]};
      end else if (inv_found) begin
         victim   = inv;
         old_rank = (RK_W + 1)'(MAX_WAYS);
      end else begin
         victim   = lru;
         old_rank = {1'b0, lru_rank};
      end
      for (int i = 0; i < MAX_WAYS; i++) begin
         nv = vld[i] || (in_use[i] ? 1'b0 : (row_live_ff[row_ff] && rd_valid[i]));
         nr = rd_rank[i];
         nt = rd_tag[i];
         if (VI_W'(i) == victim) begin
            nv = 1'b1;
            nr = '0;
            nt = tag_ff;
         end else if (vld[i] && ({1'b0, rd_rank[i]} < old_rank) &&
                      (rd_rank[i] < RK_W'(MAX_WAYS - 1))) begin
            nr = rd_rank[i] + 1'b1;
         end
         wr_data[i*WAY_W +: WAY_W] = {nv, nr, nt};
      end
   end

   assign added_now = ADDED_W'(found) + ADDED_W'(modify_ff);

   always_comb begin
      state_in       = state_ff;
      modify_in      = modify_ff;
      row_in         = row_ff;
      tag_in         = tag_ff;
      ways_in        = ways_ff;
      row_live_in    = row_live_ff;
      hit_total_in   = hit_total_ff;
      miss_total_in  = miss_total_ff;
      evict_total_in = evict_total_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ch.ready;
      hit_in         = hit_ff;
      miss_in        = miss_ff;
      evicted_in     = evicted_ff;
      added_in       = added_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (ram_re) begin
               state_in  = S_UPDATE;
               modify_in = q_modify;
               row_in    = q_row;
               tag_in    = q_tag;
               ways_in   = q_ways;
            end else if (load_ignore) begin
               rsp_valid_in = 1'b1;
               hit_in       = 1'b0;
               miss_in      = 1'b0;
               evicted_in   = 1'b0;
               added_in     = '0;
            end
         end
         S_UPDATE: begin
            if (load_update) begin
               state_in             = S_IDLE;
               row_live_in[row_ff]  = 1'b1;
               rsp_valid_in         = 1'b1;
               hit_in               = found;
               miss_in              = !found;
               evicted_in           = !found && !inv_found;
               added_in             = added_now;
               hit_total_in         = hit_total_ff + CNT_W'(added_now);
               miss_total_in        = miss_total_ff + CNT_W'(!found);
               evict_total_in       = evict_total_ff + CNT_W'(!found && !inv_found);
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         row_live_ff    <= '0;
         hit_total_ff   <= '0;
         miss_total_ff  <= '0;
         evict_total_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         row_live_ff    <= row_live_in;
         hit_total_ff   <= hit_total_in;
         miss_total_ff  <= miss_total_in;
         evict_total_ff <= evict_total_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      modify_ff  <= modify_in;
      row_ff     <= row_in;
      tag_ff     <= tag_in;
      ways_ff    <= ways_in;
      hit_ff     <= hit_in;
      miss_ff    <= miss_in;
      evicted_ff <= evicted_in;
      added_ff   <= added_in;
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.hit         = hit_ff;
   assign rsp_ch.miss        = miss_ff;
   assign rsp_ch.evicted     = evicted_ff;
   assign rsp_ch.hits_added  = added_ff;
   assign rsp_ch.hit_total   = hit_total_ff;
   assign rsp_ch.miss_total  = miss_total_ff;
   assign rsp_ch.evict_total = evict_total_ff;

endmodule

FILE: hw/rtl/set_assoc_cache_lru_model.sv
// Set-associative cache hit/miss model with LRU replacement. Each request item is a
// load, store or modify and a byte address; each gives one result item with hit, miss
// and eviction flags, the hits it adds and the running totals. The front part splits
// the address with the configured set and block bits and queues the item (two deep);
// the back part reads the set row from a single RAM, compares tags in all ways at once
// and writes the updated row back. An access reads the row while idle, then compares and
// writes on the same RAM in the update state once the result register is free; no new
// item is taken before that. An unknown command skips the RAM. Write the csr_ registers
// only while no item is in flight. Depends on sacl_pkg, sacl_req_if, sacl_rsp_if, sacl_fifo, sacl_front, sacl_back.
module set_assoc_cache_lru_model import sacl_pkg::*; #(
   parameter int MAX_SET_BITS = 6,
   parameter int MAX_WAYS     = 8,
   parameter int ADDR_WIDTH   = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   sacl_req_if.sink              req_ch,
   sacl_rsp_if.source            rsp_ch
);

   localparam int AW   = (ADDR_WIDTH < ADDR_IN_W) ? ADDR_WIDTH : ADDR_IN_W;
   localparam int WC_W = $clog2(MAX_WAYS + 1);
   localparam int QW   = 2 + MAX_SET_BITS + AW + WC_W;

   logic                    f_valid, f_ready, f_ignore, f_modify;
   logic [MAX_SET_BITS-1:0] f_row;
   logic [AW-1:0]           f_tag;
   logic [WC_W-1:0]         f_ways;
   logic                    b_valid, b_ready, b_ignore, b_modify;
   logic [MAX_SET_BITS-1:0] b_row;
   logic [AW-1:0]           b_tag;
   logic [WC_W-1:0]         b_ways;
   logic [QW-1:0]           push_data, pop_data;

   sacl_front #(
      .MAX_SET_BITS (MAX_SET_BITS),
      .MAX_WAYS     (MAX_WAYS),
      .ADDR_WIDTH   (ADDR_WIDTH)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .req_ch    (req_ch),
      .q_valid   (f_valid),
      .q_ready   (f_ready),
      .q_ignore  (f_ignore),
      .q_modify  (f_modify),
      .q_row     (f_row),
      .q_tag     (f_tag),
      .q_ways    (f_ways)
   );

   assign push_data = {f_ignore, f_modify, f_row, f_tag, f_ways};

   sacl_fifo #(
      .WIDTH (QW),
      .DEPTH (2)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (f_valid),
      .push_ready (f_ready),
      .push_data  (push_data),
      .pop_valid  (b_valid),
      .pop_ready  (b_ready),
      .pop_data   (pop_data)
   );

   assign {b_ignore, b_modify, b_row, b_tag, b_ways} = pop_data;

   sacl_back #(
      .MAX_SET_BITS (MAX_SET_BITS),
      .MAX_WAYS     (MAX_WAYS),
      .ADDR_WIDTH   (ADDR_WIDTH)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .q_valid  (b_valid),
      .q_ready  (b_ready),
      .q_ignore (b_ignore),
      .q_modify (b_modify),
      .q_row    (b_row),
      .q_tag    (b_tag),
      .q_ways   (b_ways),
      .rsp_ch   (rsp_ch)
   );

endmodule
